// ===== sv/breakpoint_table_with_hit_counts_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BREAKPOINT_TABLE_WITH_HIT_COUNTS_DEFINES_SVH
`define BREAKPOINT_TABLE_WITH_HIT_COUNTS_DEFINES_SVH

// Same-cycle implication, off during reset.
`define BP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset.
`define BP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bp_pkg.sv =====
package bp_pkg;

	localparam int LINE_W     = 16;
	localparam int HIT_W      = 16;
	localparam int IDX_W      = 4;
	localparam int IN_TDATA_W = 24;
	localparam int IN_TUSER_W = 3;

	localparam logic [HIT_W-1:0] HIT_MAX = '1;

	typedef enum logic [IN_TUSER_W-1:0] {
		CMD_CHECK  = 3'd0,
		CMD_ADD    = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_CLEAR  = 3'd3,
		CMD_READ   = 3'd4
	} cmd_t;

	// Broadcast update controls, one copy for every cell of the row.
	typedef struct packed {
		logic              check_en;
		logic              add_en;
		logic              append_en;
		logic              shift_en;
		logic [LINE_W-1:0] line;
	} bp_ctl_t;

endpackage

// ===== sv/bp_cell.sv =====
module bp_cell (
	input  logic                     clk,
	input  bp_pkg::bp_ctl_t          ctl,
	input  logic                     valid,
	input  logic                     at_tail,
	input  logic                     past_pos,
	input  logic [bp_pkg::LINE_W-1:0] nb_line,
	input  logic [bp_pkg::HIT_W-1:0]  nb_hits,
	output logic                     match,
	output logic [bp_pkg::LINE_W-1:0] line,
	output logic [bp_pkg::HIT_W-1:0]  hits
);
	import bp_pkg::*;

	logic [LINE_W-1:0] line_q;
	logic [HIT_W-1:0]  hits_q;

	// Compare the stored line with the request line
	assign match = valid && (line_q == ctl.line);
	assign line  = line_q;
	assign hits  = hits_q;

	// Shift down on remove, take the new line at the tail, clear or bump the counter
	always_ff @(posedge clk) begin
		priority if (ctl.shift_en && past_pos) begin
			line_q <= nb_line;
			hits_q <= nb_hits;
		end else if (ctl.append_en && at_tail) begin
			line_q <= ctl.line;
			hits_q <= '0;
		end else if (ctl.add_en && match) begin
			hits_q <= '0;
		end else if (ctl.check_en && match && (hits_q != HIT_MAX)) begin
			hits_q <= hits_q + HIT_W'(1);
		end else begin
			line_q <= line_q;
			hits_q <= hits_q;
		end
	end

endmodule

// ===== sv/bp_match.sv =====
module bp_match #(
	parameter int N  = 16,
	parameter int IW = 4
) (
	input  logic                     match [N],
	input  logic [bp_pkg::HIT_W-1:0] hits [N],
	output logic                     any,
	output logic [IW-1:0]            pos,
	output logic [bp_pkg::HIT_W-1:0] hit
);
	import bp_pkg::*;

	// Stored lines are unique, so at most one cell matches: fold by OR
	always_comb begin
		any = 1'b0;
		pos = '0;
		hit = '0;
		for (int i = 0; i < N; i++) begin
			if (match[i]) begin
				any = 1'b1;
				pos = pos | IW'(i);
				hit = hit | hits[i];
			end
		end
	end

endmodule

// ===== sv/breakpoint_table_with_hit_counts.sv =====
// Channel  Dir  Bits  Contents (lowest bit first)
// s_*      in   24    tdata: line_number[15:0], entry_index[19:16]; tuser: cmd[2:0]
// m_*      out  40    tdata: pause, ok, hit_count[15:0], entry_line[15:0], entry_count
//
// One request per cycle while s_tready is high; its result is registered and shows in the cycle after acceptance.
// Each entry lives in one cell of a row; all cells compare in parallel and a remove
// shifts every later cell down from its neighbor in the same cycle.
// Reset clears only the entry count and the output valid; cell contents are payload.
// s_tready drops only while a result waits and m_tready is low.
module breakpoint_table_with_hit_counts #(
	parameter int MAX_BREAKPOINTS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// line_number[15:0], entry_index[19:16], zero pad
	input  logic [bp_pkg::IN_TDATA_W-1:0]    s_tdata,
	// cmd[2:0]
	input  logic [bp_pkg::IN_TUSER_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// pause, ok, hit_count[15:0], entry_line[15:0], entry_count, zero pad
	output logic [((2 + 2 * bp_pkg::LINE_W + $clog2(MAX_BREAKPOINTS + 1)) + 7) / 8 * 8 - 1:0]
		m_tdata
);
	import bp_pkg::*;

	localparam int N       = MAX_BREAKPOINTS;
	localparam int IW      = (N > 1) ? $clog2(N) : 1;
	localparam int CNTW    = $clog2(N + 1);
	localparam int RES_W   = 2 + LINE_W + HIT_W + CNTW;
	localparam int OUT_W   = (RES_W + 7) / 8 * 8;

	logic              accept;
	logic [2:0]        cmd;
	logic [LINE_W-1:0] req_line;
	logic [IDX_W-1:0]  req_idx;

	logic [CNTW-1:0]   used_q;
	logic [CNTW-1:0]   used_nxt;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	logic              cell_match [N];
	logic [LINE_W-1:0] cell_line  [N];
	logic [HIT_W-1:0]  cell_hits  [N];

	logic              any;
	logic [IW-1:0]     pos;
	logic [HIT_W-1:0]  hit_old;
	logic [HIT_W-1:0]  hit_inc;
	logic              has_room;
	logic              rd_ok;
	logic [IW-1:0]     rd_idx;
	bp_ctl_t           ctl;

	logic              pause_c;
	logic              ok_c;
	logic [HIT_W-1:0]  hit_c;
	logic [LINE_W-1:0] eline_c;

	assign cmd      = s_tuser;
	assign req_line = s_tdata[LINE_W-1:0];
	assign req_idx  = s_tdata[LINE_W +: IDX_W];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Row of entry cells
	for (genvar g = 0; g < N; g++) begin : g_cell
		logic [LINE_W-1:0] nb_line;
		logic [HIT_W-1:0]  nb_hits;
		if (g == N - 1) begin : g_last
			assign nb_line = cell_line[g];
			assign nb_hits = cell_hits[g];
		end else begin : g_mid
			assign nb_line = cell_line[g+1];
			assign nb_hits = cell_hits[g+1];
		end
		bp_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.valid    (CNTW'(g) < used_q),
			.at_tail  (CNTW'(g) == used_q),
			.past_pos (IW'(g) >= pos),
			.nb_line  (nb_line),
			.nb_hits  (nb_hits),
			.match    (cell_match[g]),
			.line     (cell_line[g]),
			.hits     (cell_hits[g])
		);
	end

	bp_match #(
		.N  (N),
		.IW (IW)
	) u_match (
		.match (cell_match),
		.hits  (cell_hits),
		.any   (any),
		.pos   (pos),
		.hit   (hit_old)
	);

	assign hit_inc  = (hit_old == HIT_MAX) ? hit_old : hit_old + HIT_W'(1);
	assign has_room = 32'(used_q) < N;
	assign rd_idx   = IW'(req_idx);
	assign rd_ok    = (32'(req_idx) < 32'(used_q)) && (32'(req_idx) < N);

	// Derive cell controls and the result of this request
	always_comb begin
		ctl          = '0;
		ctl.line     = req_line;
		used_nxt     = used_q;
		pause_c      = 1'b0;
		ok_c         = 1'b0;
		hit_c        = '0;
		eline_c      = '0;
		unique case (cmd)
			CMD_CHECK: begin
				ctl.check_en = accept;
				pause_c      = any;
				ok_c         = any;
				hit_c        = any ? hit_inc : '0;
			end
			CMD_ADD: begin
				ctl.add_en = accept;
				if (req_line != '0) begin
					if (any) begin
						ok_c = 1'b1;
					end else if (has_room) begin
						ctl.append_en = accept;
						used_nxt      = used_q + CNTW'(1);
						ok_c          = 1'b1;
					end
				end
			end
			CMD_REMOVE: begin
				if (any) begin
					ctl.shift_en = accept;
					used_nxt     = used_q - CNTW'(1);
					ok_c         = 1'b1;
				end
			end
			CMD_CLEAR: begin
				used_nxt = '0;
				ok_c     = 1'b1;
			end
			CMD_READ: begin
				if (rd_ok) begin
					ok_c    = 1'b1;
					hit_c   = cell_hits[rd_idx];
					eline_c = cell_line[rd_idx];
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the entry count and the output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				used_q <= used_nxt;
			end
			if (s_tready) begin
				m_tvalid_q <= s_tvalid;
			end
		end
	end

	// Load the result register on each accepted request
	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= OUT_W'({used_nxt, eline_c, hit_c, ok_c, pause_c});
		end
	end

endmodule

// ===== sv/bp_checker.sv =====
`include "breakpoint_table_with_hit_counts_defines.svh"

module bp_checker #(
	parameter int MAX_BREAKPOINTS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [bp_pkg::IN_TDATA_W-1:0] s_tdata,
	input logic [bp_pkg::IN_TUSER_W-1:0] s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [((2 + 2 * bp_pkg::LINE_W + $clog2(MAX_BREAKPOINTS + 1)) + 7) / 8 * 8 - 1:0]
		m_tdata
);
	import bp_pkg::*;

	localparam int CNTW = $clog2(MAX_BREAKPOINTS + 1);

	logic              r_pause;
	logic              r_ok;
	logic [LINE_W-1:0] r_line;
	logic [CNTW-1:0]   r_count;

	assign r_pause = m_tdata[0];
	assign r_ok    = m_tdata[1];
	assign r_line  = m_tdata[2 + HIT_W +: LINE_W];
	assign r_count = m_tdata[2 + HIT_W + LINE_W +: CNTW];

	`BP_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`BP_ASSERT_NOW(a_pause_ok, m_tvalid && r_pause, r_ok && (r_line == '0), "pause without a clean match")
	`BP_ASSERT_NOW(a_count_max, m_tvalid, 32'(r_count) <= MAX_BREAKPOINTS, "entry count beyond table size")
	`BP_ASSERT_NEXT(a_clear, s_tvalid && s_tready && (s_tuser == CMD_CLEAR), m_tvalid && r_ok && (r_count == '0), "clear did not empty the table")

endmodule

bind breakpoint_table_with_hit_counts bp_checker #(
	.MAX_BREAKPOINTS (MAX_BREAKPOINTS)
) u_bp_checker (.*);
